@@ rtl/kehid_pkg.sv @@
`timescale 1ns / 1ps
package kehid_pkg;

   localparam int SLOT_COUNT = 6;

   // virtual-key codes with special handling
   localparam logic [7:0] KEY_SHIFT   = 8'h10;
   localparam logic [7:0] KEY_CONTROL = 8'h11;
   localparam logic [7:0] KEY_MENU    = 8'h12;
   localparam logic [7:0] KEY_LWIN    = 8'h5B;
   localparam logic [7:0] KEY_RWIN    = 8'h5C;
   localparam logic [7:0] KEY_RETURN  = 8'h0D;
   localparam logic [7:0] SCAN_RSHIFT = 8'h36;

   // modifier byte bits
   localparam logic [7:0] MOD_LCTRL  = 8'h01;
   localparam logic [7:0] MOD_LSHIFT = 8'h02;
   localparam logic [7:0] MOD_LALT   = 8'h04;
   localparam logic [7:0] MOD_LGUI   = 8'h08;
   localparam logic [7:0] MOD_RCTRL  = 8'h10;
   localparam logic [7:0] MOD_RSHIFT = 8'h20;
   localparam logic [7:0] MOD_RALT   = 8'h40;
   localparam logic [7:0] MOD_RGUI   = 8'h80;

   typedef logic [7:0] usage_type;
   typedef usage_type [SLOT_COUNT-1:0] slots_type;

   typedef struct packed {
      logic [7:0] key_code;
      logic       extended;
      logic [7:0] scan_code;
      logic       pressed;
      logic       clear_all;
   } event_type;

   typedef struct packed {
      logic       clear_all;
      logic       down;
      logic [7:0] mask;
      usage_type  usage;
      logic       emit;
   } action_type;

   function automatic logic [7:0] modifier_mask(input logic [7:0] code, input logic ext,
                                                input logic [7:0] scan);
      logic [7:0] m;
      unique case (code)
         KEY_CONTROL: m = ext ? MOD_RCTRL : MOD_LCTRL;
         KEY_MENU:    m = ext ? MOD_RALT : MOD_LALT;
         KEY_SHIFT:   m = (scan == SCAN_RSHIFT) ? MOD_RSHIFT : MOD_LSHIFT;
         KEY_LWIN:    m = MOD_LGUI;
         KEY_RWIN:    m = MOD_RGUI;
         default:     m = 8'h00;
      endcase
      return m;
   endfunction

   function automatic usage_type usage_of(input logic [7:0] code, input logic ext);
      usage_type u;
      if (code >= 8'h41 && code <= 8'h5A) begin
         u = 8'h04 + (code - 8'h41);
      end else if (code >= 8'h31 && code <= 8'h39) begin
         u = 8'h1E + (code - 8'h31);
      end else if (code == 8'h30) begin
         u = 8'h27;
      end else if (code >= 8'h70 && code <= 8'h7B) begin
         u = 8'h3A + (code - 8'h70);
      end else if (code >= 8'h61 && code <= 8'h69) begin
         u = 8'h59 + (code - 8'h61);
      end else begin
         unique case (code)
            KEY_RETURN: u = ext ? 8'h58 : 8'h28;
            8'h1B: u = 8'h29;
            8'h08: u = 8'h2A;
            8'h09: u = 8'h2B;
            8'h20: u = 8'h2C;
            8'hBD: u = 8'h2D;
            8'hBB: u = 8'h2E;
            8'hDB: u = 8'h2F;
            8'hDD: u = 8'h30;
            8'hDC: u = 8'h31;
            8'hBA: u = 8'h33;
            8'hDE: u = 8'h34;
            8'hC0: u = 8'h35;
            8'hBC: u = 8'h36;
            8'hBE: u = 8'h37;
            8'hBF: u = 8'h38;
            8'h14: u = 8'h39;
            8'h2C: u = 8'h46;
            8'h91: u = 8'h47;
            8'h13: u = 8'h48;
            8'h2D: u = 8'h49;
            8'h24: u = 8'h4A;
            8'h21: u = 8'h4B;
            8'h2E: u = 8'h4C;
            8'h23: u = 8'h4D;
            8'h22: u = 8'h4E;
            8'h27: u = 8'h4F;
            8'h25: u = 8'h50;
            8'h28: u = 8'h51;
            8'h26: u = 8'h52;
            8'h90: u = 8'h53;
            8'h6F: u = 8'h54;
            8'h6A: u = 8'h55;
            8'h6D: u = 8'h56;
            8'h6B: u = 8'h57;
            8'h60: u = 8'h62;
            8'h6E: u = 8'h63;
            default: u = 8'h00;
         endcase
      end
      return u;
   endfunction

   // true when no usage appears in two occupied slots
   function automatic logic slots_unique(input slots_type s);
      logic ok;
      ok = 1'b1;
      for (int i = 0; i < SLOT_COUNT; i++) begin
         for (int j = i + 1; j < SLOT_COUNT; j++) begin
            if (s[i] != 8'h00 && s[i] == s[j]) ok = 1'b0;
         end
      end
      return ok;
   endfunction

endpackage

@@ rtl/key_event_to_hid_keyboard_report.sv @@
`timescale 1ns / 1ps
// An accepted key event is registered in the input register; the state update then
// registers its report in the report register, shown on rsp_tvalid. Throughput: one
// event per cycle unless rsp_tready stalls; the two registers form a two-entry pipeline.
// Reset: synchronous, clears the modifier byte, all six slots and both valid flags.
module key_event_to_hid_keyboard_report
   import kehid_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [7:0] key_code, [8] extended, [16:9] scan_code, [17] pressed, [23:18] zero
   input  logic [23:0] req_tdata,
   // [0] clear_all
   input  logic        req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [7:0] modifiers, [15:8] key_slot_0 ... [55:48] key_slot_5
   output logic [55:0] rsp_tdata
);

   event_type   event_ff;
   logic        event_valid_ff;
   logic        rsp_valid_ff;
   logic [55:0] rsp_data_ff;
   action_type  action;
   logic [7:0]  modifiers_in;
   slots_type   slots_in;
   slots_type   slots;
   logic        req_fire;
   logic        advance;

   assign advance    = event_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !event_valid_ff || advance;
   assign req_fire   = req_tvalid && req_tready;

   kehid_decode u_decode (
      .key_event (event_ff),
      .action    (action)
   );

   kehid_state u_state (
      .clock        (clock),
      .reset        (reset),
      .update       (advance),
      .action       (action),
      .modifiers_in (modifiers_in),
      .slots_in     (slots_in),
      .slots        (slots)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         event_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (req_fire) begin
            event_valid_ff <= 1'b1;
         end else if (advance) begin
            event_valid_ff <= 1'b0;
         end
         if (advance && action.emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers: hold until the next transaction moves
   always_ff @(posedge clock) begin
      if (req_fire) begin
         event_ff.key_code  <= req_tdata[7:0];
         event_ff.extended  <= req_tdata[8];
         event_ff.scan_code <= req_tdata[16:9];
         event_ff.pressed   <= req_tdata[17];
         event_ff.clear_all <= req_tuser;
      end
      if (advance && action.emit) begin
         rsp_data_ff <= {slots_in, modifiers_in};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

`ifndef ASSERT_OFF
   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_tvalid && !event_valid_ff)
      else $error("valid flags set after reset");
   a_clear_zero: assert property (@(posedge clock) disable iff (reset)
      advance && action.clear_all |=> rsp_tvalid && rsp_tdata == 56'd0)
      else $error("clear-all report not zero");
   a_unique: assert property (@(posedge clock) disable iff (reset) slots_unique(slots))
      else $error("usage held in two slots");
   a_ready_empty: assert property (@(posedge clock) disable iff (reset)
      !event_valid_ff |-> req_tready)
      else $error("input stalled while empty");
`endif

endmodule

@@ rtl/kehid_decode.sv @@
`timescale 1ns / 1ps
module kehid_decode
   import kehid_pkg::*;
(
   input  event_type  key_event,
   output action_type action
);

   logic [7:0] mask;
   usage_type  usage;

   always_comb begin
      mask  = modifier_mask(key_event.key_code, key_event.extended, key_event.scan_code);
      usage = usage_of(key_event.key_code, key_event.extended);
      action.clear_all = key_event.clear_all;
      action.down      = key_event.pressed;
      action.mask      = mask;
      action.usage     = usage;
      // unmapped keys produce no report
      action.emit      = key_event.clear_all || (mask != 8'h00) || (usage != 8'h00);
   end

endmodule

@@ rtl/kehid_state.sv @@
`timescale 1ns / 1ps
module kehid_state
   import kehid_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       update,
   input  action_type action,
   output logic [7:0] modifiers_in,
   output slots_type  slots_in,
   output slots_type  slots
);

   logic [7:0] modifiers_ff;
   slots_type  slots_ff;
   logic       hit;
   logic       placed;

   always_comb begin
      modifiers_in = modifiers_ff;
      slots_in     = slots_ff;
      hit          = 1'b0;
      placed       = 1'b0;
      for (int i = 0; i < SLOT_COUNT; i++) begin
         if (slots_ff[i] == action.usage) hit = 1'b1;
      end
      priority if (action.clear_all) begin
         modifiers_in = 8'h00;
         slots_in     = '0;
      end else if (action.mask != 8'h00) begin
         modifiers_in = action.down ? (modifiers_ff | action.mask)
                                    : (modifiers_ff & ~action.mask);
      end else if (action.usage != 8'h00) begin
         if (action.down) begin
            // fill the lowest free slot unless already held; drop when full
            for (int i = 0; i < SLOT_COUNT; i++) begin
               if (!hit && !placed && slots_ff[i] == 8'h00) begin
                  slots_in[i] = action.usage;
                  placed      = 1'b1;
               end
            end
         end else begin
            for (int i = 0; i < SLOT_COUNT; i++) begin
               if (slots_ff[i] == action.usage) slots_in[i] = 8'h00;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         modifiers_ff <= 8'h00;
         slots_ff     <= '0;
      end else if (update) begin
         modifiers_ff <= modifiers_in;
         slots_ff     <= slots_in;
      end
   end

   assign slots = slots_ff;

endmodule
